FILE: hw/rtl/rti_pkg.sv
// Shared widths, register indexes and divider stage type for the ray/triangle unit.
`default_nettype none
package rti_pkg;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned E_W = 33;
	localparam int unsigned X_W = 67;
	localparam int unsigned DOT_W = 104;
	localparam int unsigned NUM_W = 136;
	localparam int unsigned Q_W = 31;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_MAX_DIST = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic           hit;
		logic           back;
		logic [Q_W-1:0] quo;
	} div_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rti_cross.sv
// Two-stage cross product: registered partial products, then registered differences.
`default_nettype none
module rti_cross (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic signed [rti_pkg::E_W-1:0]   a [3],
	input  wire logic signed [rti_pkg::E_W-1:0]   b [3],
	output logic signed [rti_pkg::X_W-1:0]        r [3]
);
	import rti_pkg::*;

	logic signed [2*E_W-1:0] m_s1 [6];
	logic signed [X_W-1:0]   r_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0] <= a[1] * b[2];
			m_s1[1] <= a[2] * b[1];
			m_s1[2] <= a[2] * b[0];
			m_s1[3] <= a[0] * b[2];
			m_s1[4] <= a[0] * b[1];
			m_s1[5] <= a[1] * b[0];
			for (int i = 0; i < 3; i++) begin
				r_s2[i] <= X_W'(m_s1[2*i]) - X_W'(m_s1[2*i+1]);
			end
		end
	end

	assign r = r_s2;
endmodule
`default_nettype wire

FILE: hw/rtl/rti_dot.sv
// Two-stage dot product with the wide operand split into two partial products.
`default_nettype none
module rti_dot (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic signed [rti_pkg::E_W-1:0]   a [3],
	input  wire logic signed [rti_pkg::X_W-1:0]   b [3],
	output logic signed [rti_pkg::DOT_W-1:0]      dot
);
	import rti_pkg::*;

	localparam int unsigned LO_W = 34;

	logic signed [X_W-LO_W-1:0]     b_hi [3];
	logic signed [LO_W:0]           b_lo [3];
	logic signed [E_W+X_W-LO_W-1:0] ph_s1 [3];
	logic signed [E_W+LO_W:0]       pl_s1 [3];
	logic signed [DOT_W-1:0]        dot_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			b_hi[i] = b[i][X_W-1:LO_W];
			b_lo[i] = $signed({1'b0, b[i][LO_W-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ph_s1[i] <= a[i] * b_hi[i];
				pl_s1[i] <= a[i] * b_lo[i];
			end
			dot_s2 <= (DOT_W'(ph_s1[0]) <<< LO_W) + DOT_W'(pl_s1[0])
				+ (DOT_W'(ph_s1[1]) <<< LO_W) + DOT_W'(pl_s1[1])
				+ (DOT_W'(ph_s1[2]) <<< LO_W) + DOT_W'(pl_s1[2]);
		end
	end

	assign dot = dot_s2;
endmodule
`default_nettype wire

FILE: hw/rtl/rti_div_step.sv
// One restoring-division stage: produces one quotient bit per cycle while en is high.
`default_nettype none
module rti_div_step #(
	parameter int unsigned BIT_POS = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          vld_in,
	input  wire rti_pkg::div_t                 st_in,
	input  wire logic [rti_pkg::NUM_W-1:0]     rem_in,
	input  wire logic [rti_pkg::DOT_W-1:0]     den_in,
	output logic                               vld_s1,
	output rti_pkg::div_t                      st_s1,
	output logic [rti_pkg::NUM_W-1:0]          rem_s1,
	output logic [rti_pkg::DOT_W-1:0]          den_s1
);
	import rti_pkg::*;

	logic [NUM_W:0] diff;
	logic           ge;
	div_t           st_nxt;

	assign diff = {1'b0, rem_in} - ({1'b0, NUM_W'(den_in)} << BIT_POS);
	assign ge = ~diff[NUM_W];

	always_comb begin
		st_nxt = st_in;
		st_nxt.quo[BIT_POS] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_nxt;
			rem_s1 <= ge ? diff[NUM_W-1:0] : rem_in;
			den_s1 <= den_in;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/ray_triangle_intersect_unit.sv
// Top level of the pipelined ray/triangle intersection unit.
// Tests the configured ray against one triangle per cycle while the output side keeps
// taking. Every transaction passes a fixed pipeline of 39 register stages: input edges,
// cross products (2), dot products (2), sign correction, bound tests, 31 one-bit division
// stages and the output register. The pipeline advances as a whole whenever the output
// register is empty or being read; in_ready follows that condition. Write configuration
// only while the pipeline is empty.
`default_nettype none
module ray_triangle_intersect_unit #(
	parameter int unsigned COORD_FRAC_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rti_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [rti_pkg::COORD_W-1:0]          cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_a_x,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_a_y,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_a_z,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_b_x,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_b_y,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_b_z,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_c_x,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_c_y,
	input  wire logic signed [rti_pkg::COORD_W-1:0]   vertex_c_z,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      hit,
	output logic [rti_pkg::Q_W-1:0]                   distance,
	output logic                                      back_face
);
	import rti_pkg::*;

	localparam logic [DOT_W-1:0] EPS = DOT_W'(1) << (3 * COORD_FRAC_BITS - 20);

	logic signed [COORD_W-1:0] org_q [3];
	logic signed [COORD_W-1:0] dir_q [3];
	logic [Q_W-1:0]            max_dist_q;

	logic signed [COORD_W-1:0] va [3];
	logic signed [COORD_W-1:0] vb [3];
	logic signed [COORD_W-1:0] vc [3];

	logic en;

	logic signed [E_W-1:0] e1_s1 [3], e2_s1 [3], t_s1 [3], d_s1 [3];
	logic signed [E_W-1:0] e1_s2 [3], e2_s2 [3], t_s2 [3], d_s2 [3];
	logic signed [E_W-1:0] e1_s3 [3], e2_s3 [3], t_s3 [3], d_s3 [3];
	logic signed [X_W-1:0] p_s3 [3], q_s3 [3];
	logic signed [DOT_W-1:0] det_s5, un_s5, vn_s5, tn_s5;
	logic signed [DOT_W-1:0] det_s6, un_s6, vn_s6, tn_s6;
	logic                    back_s6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [DOT_W:0]   uv_sum;
	logic [NUM_W-1:0]        num;
	logic                    pass;

	div_t             st_s7;
	logic [NUM_W-1:0] rem_s7;
	logic [DOT_W-1:0] den_s7;

	logic             dvld [Q_W+1];
	div_t             dst [Q_W+1];
	logic [NUM_W-1:0] drem [Q_W+1];
	logic [DOT_W-1:0] dden [Q_W+1];

	logic             out_valid_q, hit_q, back_q;
	logic [Q_W-1:0]   dist_q;

	assign va = '{vertex_a_x, vertex_a_y, vertex_a_z};
	assign vb = '{vertex_b_x, vertex_b_y, vertex_b_z};
	assign vc = '{vertex_c_x, vertex_c_y, vertex_c_z};

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= 32'sh0001_0000;
			max_dist_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				REG_ORIGIN_X: org_q[0] <= cfg_data;
				REG_ORIGIN_Y: org_q[1] <= cfg_data;
				REG_ORIGIN_Z: org_q[2] <= cfg_data;
				REG_DIR_X: dir_q[0] <= cfg_data;
				REG_DIR_Y: dir_q[1] <= cfg_data;
				REG_DIR_Z: dir_q[2] <= cfg_data;
				REG_MAX_DIST: max_dist_q <= cfg_data[Q_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = ~out_valid_q | out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= E_W'(vb[i]) - E_W'(va[i]);
				e2_s1[i] <= E_W'(vc[i]) - E_W'(va[i]);
				t_s1[i] <= E_W'(org_q[i]) - E_W'(va[i]);
				d_s1[i] <= E_W'(dir_q[i]);
			end
			e1_s2 <= e1_s1;
			e2_s2 <= e2_s1;
			t_s2 <= t_s1;
			d_s2 <= d_s1;
			e1_s3 <= e1_s2;
			e2_s3 <= e2_s2;
			t_s3 <= t_s2;
			d_s3 <= d_s2;
		end
	end

	rti_cross u_cross_p (.clk(clk), .en(en), .a(d_s1), .b(e2_s1), .r(p_s3));
	rti_cross u_cross_q (.clk(clk), .en(en), .a(t_s1), .b(e1_s1), .r(q_s3));

	rti_dot u_dot_det (.clk(clk), .en(en), .a(e1_s3), .b(p_s3), .dot(det_s5));
	rti_dot u_dot_un  (.clk(clk), .en(en), .a(t_s3),  .b(p_s3), .dot(un_s5));
	rti_dot u_dot_vn  (.clk(clk), .en(en), .a(d_s3),  .b(q_s3), .dot(vn_s5));
	rti_dot u_dot_tn  (.clk(clk), .en(en), .a(e2_s3), .b(q_s3), .dot(tn_s5));

	always_ff @(posedge clk) begin
		if (en) begin
			back_s6 <= det_s5[DOT_W-1];
			det_s6 <= det_s5[DOT_W-1] ? -det_s5 : det_s5;
			un_s6 <= det_s5[DOT_W-1] ? -un_s5 : un_s5;
			vn_s6 <= det_s5[DOT_W-1] ? -vn_s5 : vn_s5;
			tn_s6 <= det_s5[DOT_W-1] ? -tn_s5 : tn_s5;
		end
	end

	assign uv_sum = (DOT_W+1)'(un_s6) + (DOT_W+1)'(vn_s6);
	assign num = NUM_W'(unsigned'(tn_s6)) << COORD_FRAC_BITS;
	assign pass = (unsigned'(det_s6) >= EPS)
		&& !un_s6[DOT_W-1] && (un_s6 <= det_s6)
		&& !vn_s6[DOT_W-1] && (uv_sum <= (DOT_W+1)'(det_s6))
		&& !tn_s6[DOT_W-1]
		&& (num < (NUM_W'(unsigned'(det_s6)) << Q_W));

	always_ff @(posedge clk) begin
		if (en) begin
			st_s7.hit <= pass;
			st_s7.back <= back_s6;
			st_s7.quo <= '0;
			rem_s7 <= num;
			den_s7 <= unsigned'(det_s6);
		end
	end

	assign dvld[0] = vld_s7;
	assign dst[0] = st_s7;
	assign drem[0] = rem_s7;
	assign dden[0] = den_s7;

	for (genvar k = 0; k < Q_W; k++) begin : g_div
		rti_div_step #(.BIT_POS(Q_W - 1 - k)) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_in(dvld[k]),
			.st_in(dst[k]),
			.rem_in(drem[k]),
			.den_in(dden[k]),
			.vld_s1(dvld[k+1]),
			.st_s1(dst[k+1]),
			.rem_s1(drem[k+1]),
			.den_s1(dden[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dvld[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= dst[Q_W].hit && (dst[Q_W].quo <= max_dist_q);
			back_q <= dst[Q_W].hit && (dst[Q_W].quo <= max_dist_q) && dst[Q_W].back;
			dist_q <= (dst[Q_W].hit && (dst[Q_W].quo <= max_dist_q)) ? dst[Q_W].quo : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign distance = dist_q;
	assign back_face = back_q;

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == '0 && !back_face)
		else $error("miss result carries nonzero fields");
	a_back_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && back_face |-> hit)
		else $error("back face flagged on a miss");
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> distance <= max_dist_q)
		else $error("hit distance beyond maximum");
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline stalled");
`endif
endmodule
`default_nettype wire

FILE: dv/rti_checker.sv
// Checker for the ray/triangle unit: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module rti_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	input  wire logic                                  cfg_ready,
	input  wire logic [rti_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [rti_pkg::COORD_W-1:0]           cfg_data,
	input  wire logic                                  in_valid,
	input  wire logic                                  in_ready,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_a_x,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_a_y,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_a_z,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_b_x,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_b_y,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_b_z,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_c_x,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_c_y,
	input  wire logic signed [rti_pkg::COORD_W-1:0]    vertex_c_z,
	input  wire logic                                  out_valid,
	input  wire logic                                  out_ready,
	input  wire logic                                  hit,
	input  wire logic [rti_pkg::Q_W-1:0]               distance,
	input  wire logic                                  back_face,
	output int                                         errors,
	output int                                         pending
);
	import rti_pkg::*;

	localparam int FRAC = 16;
	localparam int DUE_DEPTH = 64;

	typedef logic signed [255:0] wide_t;
	typedef struct packed {
		logic           hit;
		logic [Q_W-1:0] dist_val;
		logic           back;
	} hit_rec_t;

	logic signed [COORD_W-1:0] org_x, org_y, org_z, ray_x, ray_y, ray_z;
	logic [Q_W-1:0] max_d;
	hit_rec_t due_mem [DUE_DEPTH];
	int due_wr, due_rd;

	function automatic hit_rec_t predict_hit();
		wide_t ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, tx, ty, tz, dx, dy, dz;
		wide_t px, py, pz, qx, qy, qz, det, un, vn, tn, num, lim, quo;
		hit_rec_t r;
		logic back;
		r = '0;
		ax = vertex_a_x; ay = vertex_a_y; az = vertex_a_z;
		e1x = vertex_b_x; e1y = vertex_b_y; e1z = vertex_b_z;
		e2x = vertex_c_x; e2y = vertex_c_y; e2z = vertex_c_z;
		e1x = e1x - ax; e1y = e1y - ay; e1z = e1z - az;
		e2x = e2x - ax; e2y = e2y - ay; e2z = e2z - az;
		tx = org_x; ty = org_y; tz = org_z;
		tx = tx - ax; ty = ty - ay; tz = tz - az;
		dx = ray_x; dy = ray_y; dz = ray_z;
		px = dy * e2z - dz * e2y;
		py = dz * e2x - dx * e2z;
		pz = dx * e2y - dy * e2x;
		det = e1x * px + e1y * py + e1z * pz;
		back = det < 0;
		if (back)
			det = -det;
		if (det < (wide_t'(1) <<< (3 * FRAC - 20)))
			return r;
		qx = ty * e1z - tz * e1y;
		qy = tz * e1x - tx * e1z;
		qz = tx * e1y - ty * e1x;
		un = tx * px + ty * py + tz * pz;
		vn = dx * qx + dy * qy + dz * qz;
		tn = e2x * qx + e2y * qy + e2z * qz;
		if (back) begin
			un = -un; vn = -vn; tn = -tn;
		end
		if (un < 0 || un > det || vn < 0 || un + vn > det || tn < 0)
			return r;
		num = tn <<< FRAC;
		lim = max_d;
		lim = (lim + 1) * det;
		if (num >= lim)
			return r;
		quo = num / det;
		r.hit = 1'b1;
		r.dist_val = quo[Q_W-1:0];
		r.back = back;
		return r;
	endfunction

	assign pending = due_wr - due_rd;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x <= '0; org_y <= '0; org_z <= '0;
			ray_x <= '0; ray_y <= '0; ray_z <= 32'sd65536;
			max_d <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X: org_x <= cfg_data;
				REG_ORIGIN_Y: org_y <= cfg_data;
				REG_ORIGIN_Z: org_z <= cfg_data;
				REG_DIR_X:    ray_x <= cfg_data;
				REG_DIR_Y:    ray_y <= cfg_data;
				REG_DIR_Z:    ray_z <= cfg_data;
				REG_MAX_DIST: max_d <= cfg_data[Q_W-1:0];
				default: ;
			endcase
		end
	end

	initial begin
		errors = 0;
		due_wr = 0;
		due_rd = 0;
	end

	always @(posedge clk) begin
		hit_rec_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				due_mem[due_wr % DUE_DEPTH] = predict_hit();
				due_wr++;
			end
			if (out_valid && out_ready) begin
				if (due_wr == due_rd) begin
					$display("%0t: unexpected result hit=%0b distance=%0d back_face=%0b",
						$time, hit, distance, back_face);
					errors++;
				end else begin
					want = due_mem[due_rd % DUE_DEPTH];
					due_rd++;
					if (hit !== want.hit) begin
						$display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
						errors++;
					end
					if (distance !== want.dist_val) begin
						$display("%0t: distance expected %0d actual %0d",
							$time, want.dist_val, distance);
						errors++;
					end
					if (back_face !== want.back) begin
						$display("%0t: back_face expected %0b actual %0b",
							$time, want.back, back_face);
						errors++;
					end
				end
			end
		end
	end
endmodule

FILE: dv/tb_ray_triangle_intersect_unit.sv
// Testbench top for the ray/triangle unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_ray_triangle_intersect_unit;
	import rti_pkg::*;

	localparam int ONE = 65536;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	logic out_valid, out_ready, hit, back_face;
	logic [Q_W-1:0] distance;
	int errors, pending;
	int stall_mode, stall_left;
	logic signed [COORD_W-1:0] cur_org [3];
	logic signed [COORD_W-1:0] cur_dir [3];

	ray_triangle_intersect_unit dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready,
		.vertex_a_x(ax), .vertex_a_y(ay), .vertex_a_z(az),
		.vertex_b_x(bx), .vertex_b_y(by), .vertex_b_z(bz),
		.vertex_c_x(cx), .vertex_c_y(cy), .vertex_c_z(cz),
		.out_valid, .out_ready, .hit, .distance, .back_face
	);

	rti_checker u_checker (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready,
		.vertex_a_x(ax), .vertex_a_y(ay), .vertex_a_z(az),
		.vertex_b_x(bx), .vertex_b_y(by), .vertex_b_z(bz),
		.vertex_c_x(cx), .vertex_c_y(cy), .vertex_c_z(cz),
		.out_valid, .out_ready, .hit, .distance, .back_face,
		.errors, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_left <= $urandom_range(8, 64);
			end else
				stall_left <= stall_left - 1;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [COORD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= REG_DIR_Z) begin
			if (idx < REG_DIR_X)
				cur_org[idx] = value;
			else
				cur_dir[idx - REG_DIR_X] = value;
		end
	endtask

	task automatic set_ray(input logic [COORD_W-1:0] ox, oy, oz, dx, dy, dz,
			input logic [COORD_W-1:0] reach);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_DIR_Z, dz);
		write_reg(REG_MAX_DIST, reach);
	endtask

	task automatic send_tri(input logic signed [COORD_W-1:0] a0, a1, a2, b0, b1, b2,
			c0, c1, c2, input int gap);
		in_valid <= 1'b1;
		ax <= a0; ay <= a1; az <= a2;
		bx <= b0; by <= b1; bz <= b2;
		cx <= c0; cy <= c1; cz <= c2;
		do @(posedge clk); while (!in_ready);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] jitter();
		return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
	endfunction

	function automatic logic signed [COORD_W-1:0] far_coord();
		case ($urandom_range(0, 3))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			default: return $urandom();
		endcase
	endfunction

	// Random triangles: most lie around points along the ray, the rest are noise or extreme.
	task automatic random_tris(input int count);
		int kind, step, burst;
		logic signed [COORD_W-1:0] ctr [3];
		logic signed [COORD_W-1:0] v [9];
		burst = $urandom_range(1, 12);
		repeat (count) begin
			kind = $urandom_range(0, 9);
			step = $urandom_range(0, 6);
			for (int k = 0; k < 3; k++)
				ctr[k] = cur_org[k] + (cur_dir[k] >>> 2) * step + $signed($urandom_range(0, 2*ONE)) - ONE;
			for (int k = 0; k < 9; k++) begin
				if (kind < 7)
					v[k] = ctr[k % 3] + jitter();
				else if (kind < 9)
					v[k] = $urandom();
				else
					v[k] = far_coord();
			end
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				send_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
					$urandom_range(1, 6));
			end else
				send_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], 0);
		end
	endtask

	initial begin
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0;
		ax = '0; ay = '0; az = '0; bx = '0; by = '0; bz = '0; cx = '0; cy = '0; cz = '0;
		cur_org = '{0, 0, 0};
		cur_dir = '{0, 0, ONE};
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 0);
		send_tri(-ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, ONE, -ONE, 5*ONE, 0);
		send_tri(0, 0, 3*ONE, 2*ONE, 0, 3*ONE, 0, 2*ONE, 3*ONE, 1);
		send_tri(-ONE, -ONE, -5*ONE, ONE, -ONE, -5*ONE, 0, ONE, -5*ONE, 0);
		send_tri(9*ONE, -ONE, 5*ONE, 11*ONE, -ONE, 5*ONE, 10*ONE, ONE, 5*ONE, 2);
		send_tri(-ONE, 0, 0, ONE, 0, ONE, 0, 0, 2*ONE, 0);
		send_tri(0, 0, ONE, 1, 0, ONE, 0, 1, ONE, 0);
		send_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 0);
		send_tri(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
		send_tri(32'sh80000000, 32'sh80000000, ONE, 32'sh7FFFFFFF, 32'sh80000000, ONE,
			0, 32'sh7FFFFFFF, ONE, 3);
		send_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0);
		send_tri(-ONE, -ONE, 32'sh7FFFFFFF, ONE, -ONE, 32'sh7FFFFFFF, 0, ONE, 32'sh7FFFFFFF, 0);
		drain();

		set_ray(0, 0, 0, 0, 0, ONE, 2*ONE);
		write_reg(cfg_idx_t'(7), 32'hDEAD_BEEF);
		send_tri(-ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, 0, ONE, 2*ONE, 0);
		send_tri(-ONE, -ONE, 2*ONE + 1, ONE, -ONE, 2*ONE + 1, 0, ONE, 2*ONE + 1, 0);
		send_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 0);
		drain();
		write_reg(REG_MAX_DIST, 0);
		send_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 0);
		send_tri(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1, 0);
		drain();

		write_reg(REG_MAX_DIST, 32'hFFFF_FFFF);
		random_tris(80);
		drain();

		set_ray($urandom(), $urandom(), $urandom(), $urandom_range(0, 4*ONE) - 2*ONE,
			$urandom_range(0, 4*ONE) - 2*ONE, $urandom_range(0, 4*ONE) - 2*ONE,
			$urandom_range(ONE, 40*ONE));
		random_tris(80);
		drain();

		set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF);
		random_tris(40);
		drain();

		set_ray(3*ONE, -2*ONE, ONE, ONE, ONE, -ONE, 32'h7FFF_FFFF);
		random_tris(80);
		drain();

		set_ray($urandom_range(0, 20*ONE) - 10*ONE, $urandom_range(0, 20*ONE) - 10*ONE,
			$urandom_range(0, 20*ONE) - 10*ONE, $urandom(), $urandom(), $urandom(),
			$urandom());
		random_tris(40);
		drain();

		set_ray(0, 0, 0, 2*ONE, -ONE, ONE / 2, 6*ONE);
		random_tris(80);
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
